[rtl/dlr_pkg.sv]
// Shared types and constants for the DDA line rasterizer.
// No dependencies; every other file in rtl/ imports this package.
package dlr_pkg;

    // Field widths and fixed-point formats.
    localparam int COORD_BITS   = 10;
    localparam int FRAC_BITS    = 16;
    localparam int RGB_BITS     = 24;
    localparam int POS_BITS     = COORD_BITS + 1 + FRAC_BITS;
    localparam int STEP_BITS    = FRAC_BITS + 2;
    localparam int CNT_BITS     = COORD_BITS + 1;
    localparam int DIV_CNT_BITS = $clog2(FRAC_BITS);

    // Half a pixel in the position format.
    localparam logic [POS_BITS-1:0] POS_HALF = POS_BITS'(1) << (FRAC_BITS - 1);

    // Action codes of an input item.
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_NEXT  = 1'b1;

    // Controller states.
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DIV
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic next;
        logic div_step;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_valid;
        logic div_last;
    } t_dp_stat;

endpackage

[rtl/dlr_ctrl.sv]
// Controller state machine of the DDA line rasterizer.
// Depends on dlr_pkg; drives the command struct of dlr_datapath.
module dlr_ctrl
    import dlr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic     i_action,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Input is taken only when idle and the output register is free or draining.
    assign o_in_ready = (r_state == ST_IDLE) && (!i_stat.out_valid || i_out_ready);
    assign accept     = i_valid && o_in_ready;

    // Next state and datapath commands.
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_action == ACT_START)) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_DIV;
                end
                if (accept && (i_action == ACT_NEXT)) begin
                    o_cmd.next = 1'b1;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // The input is closed for the whole division.
    a_no_ready_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> !o_in_ready)
        else $error("input ready raised during division");

    // A start transfer always launches the divider.
    a_start_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_action == ACT_START)) |=> (r_state == ST_DIV))
        else $error("start transfer did not enter division");

    // The last divider step returns to idle.
    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DIV) && i_stat.div_last) |=> (r_state == ST_IDLE))
        else $error("division did not end after its last step");

endmodule

[rtl/dlr_datapath.sv]
// Datapath of the DDA line rasterizer: setup, step divider, position
// accumulators, color register and output register. Depends on dlr_pkg.
module dlr_datapath
    import dlr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    input  logic                  i_cfg_we,
    input  logic [RGB_BITS-1:0]   i_cfg_data,
    input  logic                  i_out_ready,
    output t_dp_stat              o_stat,
    output logic                  o_valid,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic [RGB_BITS-1:0]   o_pixel_rgb,
    output logic                  o_last_pixel
);

    // Line state.
    logic signed [POS_BITS-1:0]  r_pos_x, n_pos_x;
    logic signed [POS_BITS-1:0]  r_pos_y, n_pos_y;
    logic signed [STEP_BITS-1:0] r_step_x, n_step_x;
    logic signed [STEP_BITS-1:0] r_step_y, n_step_y;
    logic [CNT_BITS-1:0]         r_left, n_left;
    logic                        r_active, n_active;

    // Divider state.
    logic [COORD_BITS-1:0]   r_len, n_len;
    logic [COORD_BITS-1:0]   r_rem_x, n_rem_x;
    logic [COORD_BITS-1:0]   r_rem_y, n_rem_y;
    logic [FRAC_BITS-1:0]    r_q_x, n_q_x;
    logic [FRAC_BITS-1:0]    r_q_y, n_q_y;
    logic                    r_full_x, n_full_x;
    logic                    r_full_y, n_full_y;
    logic                    r_neg_x, n_neg_x;
    logic                    r_neg_y, n_neg_y;
    logic [DIV_CNT_BITS-1:0] r_div_cnt, n_div_cnt;

    // Color and output register.
    logic [RGB_BITS-1:0]   r_color, n_color;
    logic                  r_o_valid, n_o_valid;
    logic [COORD_BITS-1:0] r_o_x, n_o_x;
    logic [COORD_BITS-1:0] r_o_y, n_o_y;
    logic [RGB_BITS-1:0]   r_o_rgb, n_o_rgb;
    logic                  r_o_last, n_o_last;

    // Setup terms.
    logic [COORD_BITS-1:0] adx, ady, len;
    logic [POS_BITS-1:0]   base_x, base_y;
    // Divider step terms.
    logic [COORD_BITS:0]   dbl_x, dbl_y;
    logic                  bit_x, bit_y;
    logic [FRAC_BITS:0]    mag_x, mag_y;
    // Emit terms.
    logic                  emit;
    logic [POS_BITS-1:0]   adj_x, adj_y;

    // Line setup: absolute differences, length and start positions.
    always_comb begin
        adx    = (i_x_start > i_x_end) ? (i_x_start - i_x_end) : (i_x_end - i_x_start);
        ady    = (i_y_start > i_y_end) ? (i_y_start - i_y_end) : (i_y_end - i_y_start);
        len    = (adx > ady) ? adx : ady;
        base_x = {1'b0, i_x_start, {FRAC_BITS{1'b0}}};
        base_y = {1'b0, i_y_start, {FRAC_BITS{1'b0}}};
    end

    // One restoring-division step per axis; the remainder stays at or below the length.
    always_comb begin
        dbl_x = {r_rem_x, 1'b0};
        dbl_y = {r_rem_y, 1'b0};
        bit_x = (dbl_x >= {1'b0, r_len});
        bit_y = (dbl_y >= {1'b0, r_len});
    end

    // Truncation toward zero: a negative position is rounded up before the shift.
    always_comb begin
        adj_x = r_pos_x + (r_pos_x[POS_BITS-1] ? POS_BITS'((1 << FRAC_BITS) - 1) : '0);
        adj_y = r_pos_y + (r_pos_y[POS_BITS-1] ? POS_BITS'((1 << FRAC_BITS) - 1) : '0);
        emit  = i_cmd.next && r_active && (r_left != '0);
    end

    // Next-state logic of the whole datapath.
    always_comb begin
        n_pos_x   = r_pos_x;
        n_pos_y   = r_pos_y;
        n_step_x  = r_step_x;
        n_step_y  = r_step_y;
        n_left    = r_left;
        n_active  = r_active;
        n_len     = r_len;
        n_rem_x   = r_rem_x;
        n_rem_y   = r_rem_y;
        n_q_x     = r_q_x;
        n_q_y     = r_q_y;
        n_full_x  = r_full_x;
        n_full_y  = r_full_y;
        n_neg_x   = r_neg_x;
        n_neg_y   = r_neg_y;
        n_div_cnt = r_div_cnt;
        n_color   = i_cfg_we ? i_cfg_data : r_color;
        n_o_x     = r_o_x;
        n_o_y     = r_o_y;
        n_o_rgb   = r_o_rgb;
        n_o_last  = r_o_last;
        n_o_valid = (r_o_valid && i_out_ready) ? 1'b0 : r_o_valid;
        mag_x     = '0;
        mag_y     = '0;

        // Start: load the divider and the offset start positions.
        if (i_cmd.start) begin
            n_len     = len;
            n_rem_x   = adx;
            n_rem_y   = ady;
            n_q_x     = '0;
            n_q_y     = '0;
            n_full_x  = (adx == len) && (len != '0);
            n_full_y  = (ady == len) && (len != '0);
            n_neg_x   = (i_x_end < i_x_start);
            n_neg_y   = (i_y_end < i_y_start);
            n_div_cnt = '0;
            if (i_x_end > i_x_start) begin
                n_pos_x = base_x + POS_HALF;
            end else if (i_x_end < i_x_start) begin
                n_pos_x = base_x - POS_HALF;
            end else begin
                n_pos_x = base_x;
            end
            if (i_y_end > i_y_start) begin
                n_pos_y = base_y + POS_HALF;
            end else if (i_y_end < i_y_start) begin
                n_pos_y = base_y - POS_HALF;
            end else begin
                n_pos_y = base_y;
            end
            n_left   = {1'b0, len} + CNT_BITS'(1);
            n_active = 1'b1;
        end

        // Division: one quotient bit per axis per cycle; steps land on the last one.
        if (i_cmd.div_step) begin
            n_rem_x   = bit_x ? COORD_BITS'(dbl_x - {1'b0, r_len}) : dbl_x[COORD_BITS-1:0];
            n_rem_y   = bit_y ? COORD_BITS'(dbl_y - {1'b0, r_len}) : dbl_y[COORD_BITS-1:0];
            n_q_x     = {r_q_x[FRAC_BITS-2:0], bit_x};
            n_q_y     = {r_q_y[FRAC_BITS-2:0], bit_y};
            n_div_cnt = r_div_cnt + DIV_CNT_BITS'(1);
            mag_x     = r_full_x ? (FRAC_BITS+1)'(1) << FRAC_BITS
                                 : (r_len == '0) ? '0 : {1'b0, n_q_x};
            mag_y     = r_full_y ? (FRAC_BITS+1)'(1) << FRAC_BITS
                                 : (r_len == '0) ? '0 : {1'b0, n_q_y};
            if (o_stat.div_last) begin
                n_step_x = r_neg_x ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
                n_step_y = r_neg_y ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
            end
        end

        // Next pixel: register the output and advance the accumulators.
        if (i_cmd.next) begin
            if (emit) begin
                n_o_valid = 1'b1;
                n_o_x     = adj_x[FRAC_BITS +: COORD_BITS];
                n_o_y     = adj_y[FRAC_BITS +: COORD_BITS];
                n_o_rgb   = r_color;
                n_o_last  = (r_left == CNT_BITS'(1));
                n_left    = r_left - CNT_BITS'(1);
                n_active  = (r_left != CNT_BITS'(1));
                n_pos_x   = r_pos_x + {{(POS_BITS-STEP_BITS){r_step_x[STEP_BITS-1]}}, r_step_x};
                n_pos_y   = r_pos_y + {{(POS_BITS-STEP_BITS){r_step_y[STEP_BITS-1]}}, r_step_y};
            end else begin
                n_active = 1'b0;
            end
        end
    end

    // Control and line state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_step_x  <= '0;
            r_step_y  <= '0;
            r_left    <= '0;
            r_active  <= 1'b0;
            r_div_cnt <= '0;
            r_color   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_pos_x   <= n_pos_x;
            r_pos_y   <= n_pos_y;
            r_step_x  <= n_step_x;
            r_step_y  <= n_step_y;
            r_left    <= n_left;
            r_active  <= n_active;
            r_div_cnt <= n_div_cnt;
            r_color   <= n_color;
            r_o_valid <= n_o_valid;
        end
    end

    // Divider and output payload registers.
    always_ff @(posedge i_clk) begin
        r_len    <= n_len;
        r_rem_x  <= n_rem_x;
        r_rem_y  <= n_rem_y;
        r_q_x    <= n_q_x;
        r_q_y    <= n_q_y;
        r_full_x <= n_full_x;
        r_full_y <= n_full_y;
        r_neg_x  <= n_neg_x;
        r_neg_y  <= n_neg_y;
        r_o_x    <= n_o_x;
        r_o_y    <= n_o_y;
        r_o_rgb  <= n_o_rgb;
        r_o_last <= n_o_last;
    end

    assign o_stat.out_valid = r_o_valid;
    assign o_stat.div_last  = (r_div_cnt == DIV_CNT_BITS'(FRAC_BITS - 1));
    assign o_valid          = r_o_valid;
    assign o_pixel_x        = r_o_x;
    assign o_pixel_y        = r_o_y;
    assign o_pixel_rgb      = r_o_rgb;
    assign o_last_pixel     = r_o_last;

    // The final pixel closes the line and is flagged.
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && (r_left == CNT_BITS'(1))) |=> (!r_active && r_o_last && r_o_valid))
        else $error("final pixel did not close the line");

    // A next request with no active line produces no pixel.
    a_idle_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.next && !r_active && !r_o_valid) |=> !r_o_valid)
        else $error("pixel produced with no active line");

endmodule

[rtl/dda_line_rasterizer_top.sv]
// Top level of the DDA line rasterizer: joins the controller and datapath.
// Depends on dlr_pkg, dlr_ctrl and dlr_datapath.
//
//  Channel   Handshake             Payload
//  input     i_valid / o_ready     i_action, i_x_start, i_y_start, i_x_end, i_y_end
//  output    o_valid / i_ready     o_pixel_x, o_pixel_y, o_pixel_rgb, o_last_pixel
//  config    i_cfg_we              i_cfg_data (pixel color)
//
// A next-pixel transfer puts its pixel in the output register, where it sits;
// the next transfer is taken in the same cycle that the pixel leaves.
// A start transfer launches the step divider, which makes one quotient bit per
// cycle for both axes; input ready stays low meanwhile.
// Reset is synchronous and active low and clears all line and color state.
// A stalled output holds input ready low until the pixel is taken.
module dda_line_rasterizer_top
    import dlr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_action,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic [RGB_BITS-1:0]   o_pixel_rgb,
    output logic                  o_last_pixel,
    input  logic                  i_cfg_we,
    input  logic [RGB_BITS-1:0]   i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer.
    dlr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_action    (i_action),
        .i_out_ready (i_ready),
        .i_stat      (stat),
        .o_in_ready  (o_ready),
        .o_cmd       (cmd)
    );

    // Arithmetic and storage.
    dlr_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_x_start    (i_x_start),
        .i_y_start    (i_y_start),
        .i_x_end      (i_x_end),
        .i_y_end      (i_y_end),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_out_ready  (i_ready),
        .o_stat       (stat),
        .o_valid      (o_valid),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_pixel_rgb  (o_pixel_rgb),
        .o_last_pixel (o_last_pixel)
    );

endmodule
